// File: rtl/euler_xyz_to_rotation_matrix_assert.svh
// assertion macros for the euler angle to rotation matrix block
`ifndef EULER_XYZ_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_XYZ_TO_ROTATION_MATRIX_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define EXM_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define EXM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/exm_pkg.sv
// shared types and constants for the euler angle to rotation matrix block
package exm_pkg;

    localparam int ANG_W = 18;
    localparam int Q16_W = 18;
    localparam int CW = 34;   // cordic x/y/z datapath width

    localparam logic signed [CW-1:0] ANG_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd843314857;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Q16_W-1:0] ONE_Q16 = 18'sd65536;

    typedef logic signed [Q16_W-1:0] q16_t;

    typedef struct packed {
        q16_t sx;
        q16_t cx;
        q16_t sy;
        q16_t cy;
        q16_t sz;
        q16_t cz;
    } trig_t;

    function automatic logic signed [CW-1:0] atan_q29(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0: r = 34'sd421657428;
            1: r = 34'sd248918915;
            2: r = 34'sd131521918;
            3: r = 34'sd66762579;
            4: r = 34'sd33510843;
            5: r = 34'sd16771758;
            6: r = 34'sd8387925;
            7: r = 34'sd4194219;
            8: r = 34'sd2097141;
            9: r = 34'sd1048575;
            default: r = 34'sd1 <<< (29 - i);
        endcase
        return r;
    endfunction

endpackage

// File: rtl/euler_xyz_to_rotation_matrix.sv
// top level: euler xyz angles to rotation matrix, fully pipelined
//  channel | direction | tdata fields (low bit up)
//  s_axis  | in        | rot_x, rot_y, rot_z (18 bits each, 56-bit bus)
//  m_axis  | out       | n_x n_y n_z o_x o_y o_z a_x a_y a_z (18 bits each, 168-bit bus)
// one transaction per cycle while the output is not stalled; register stages: fold, the
// rotations, cordic round, two product stages, the sum stage and the output round
// the whole pipeline advances when the output register is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated
// reset clears only the valid bits
`include "euler_xyz_to_rotation_matrix_assert.svh"
module euler_xyz_to_rotation_matrix import exm_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // rot_x, rot_y, rot_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata    // n_x n_y n_z o_x o_y o_z a_x a_y a_z
);

    localparam int NS = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int LAT = NS + 6;

    logic en;
    logic [LAT-1:0] vld_reg;
    trig_t trig;
    q16_t ent [9];

    assign en = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= LAT'({vld_reg, s_axis_tvalid});
    end

    exm_cordic #(.STAGES(CORDIC_STAGES)) u_cx (.aclk, .en,
        .angle(s_axis_tdata[17:0]), .sin_q(trig.sx), .cos_q(trig.cx));
    exm_cordic #(.STAGES(CORDIC_STAGES)) u_cy (.aclk, .en,
        .angle(s_axis_tdata[35:18]), .sin_q(trig.sy), .cos_q(trig.cy));
    exm_cordic #(.STAGES(CORDIC_STAGES)) u_cz (.aclk, .en,
        .angle(s_axis_tdata[53:36]), .sin_q(trig.sz), .cos_q(trig.cz));

    exm_matrix u_mat (.aclk, .en, .trig, .ent);

    assign m_axis_tdata = {6'b0, ent[8], ent[7], ent[6], ent[5], ent[4],
                           ent[3], ent[2], ent[1], ent[0]};

    `EXM_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_axis_tvalid, s_axis_tready,
        "ready low with empty output")
    `EXM_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `EXM_ASSERT_IMPL(a_range, aclk, aresetn, m_axis_tvalid,
        $signed(m_axis_tdata[17:0]) <= $signed(ONE_Q16) && $signed(m_axis_tdata[17:0]) >= -$signed(ONE_Q16),
        "n_x out of range")

endmodule

// File: rtl/exm_cordic.sv
// pipelined quadrant-folding cordic producing sine and cosine in q1.16
module exm_cordic import exm_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] angle,
    output q16_t                    sin_q,
    output q16_t                    cos_q
);

    localparam int NS = (STAGES < 24) ? STAGES : 24;

    logic signed [CW-1:0] x_reg [0:NS];
    logic signed [CW-1:0] y_reg [0:NS];
    logic signed [CW-1:0] z_reg [0:NS];
    logic                 neg_reg [0:NS];

    logic signed [CW-1:0] z_in;
    assign z_in = CW'(angle) <<< 14;

    // fold stage
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            if (z_in > ANG_HALF_PI) begin
                z_reg[0] <= z_in - ANG_PI;
                neg_reg[0] <= 1'b1;
            end else if (z_in < -ANG_HALF_PI) begin
                z_reg[0] <= z_in + ANG_PI;
                neg_reg[0] <= 1'b1;
            end else begin
                z_reg[0] <= z_in;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q29(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q29(i);
                end
            end
        end
    end

    function automatic q16_t fin(input logic signed [CW-1:0] v, input logic neg);
        logic signed [CW-1:0] r;
        q16_t s;
        r = (v + 34'sd8192) >>> 14;
        if (r > CW'(ONE_Q16)) s = ONE_Q16;
        else if (r < -CW'(ONE_Q16)) s = -ONE_Q16;
        else s = r[Q16_W-1:0];
        return neg ? -s : s;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_q <= fin(x_reg[NS], neg_reg[NS]);
            sin_q <= fin(y_reg[NS], neg_reg[NS]);
        end
    end

endmodule

// File: rtl/exm_matrix.sv
// pipelined products forming the nine rotation matrix entries
module exm_matrix import exm_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  trig_t trig,
    output q16_t  ent [9]
);

    localparam int P2 = 36;
    localparam int P3 = 54;

    // stage 1: two-factor products, q.32
    logic signed [P2-1:0] czcy_reg, szcy_reg, cysx_reg, cycx_reg;
    logic signed [P2-1:0] czsy_reg, szsy_reg, szcx_reg, szsx_reg, czcx_reg, czsx_reg;
    q16_t sx1_reg, cx1_reg, sy1_reg;
    // stage 2: three-factor products, q.48
    logic signed [P3-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [P3-1:0] u1_reg, u2_reg, u3_reg, u4_reg;
    logic signed [P2-1:0] czcy2_reg, szcy2_reg, cysx2_reg, cycx2_reg;
    q16_t sy2_reg;
    // stage 3: sums
    logic signed [P3:0] s_reg [6];
    q16_t sy3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            czcy_reg <= P2'(trig.cz * trig.cy);
            szcy_reg <= P2'(trig.sz * trig.cy);
            cysx_reg <= P2'(trig.cy * trig.sx);
            cycx_reg <= P2'(trig.cy * trig.cx);
            czsy_reg <= P2'(trig.cz * trig.sy);
            szsy_reg <= P2'(trig.sz * trig.sy);
            szcx_reg <= P2'(trig.sz * trig.cx);
            szsx_reg <= P2'(trig.sz * trig.sx);
            czcx_reg <= P2'(trig.cz * trig.cx);
            czsx_reg <= P2'(trig.cz * trig.sx);
            sx1_reg <= trig.sx;
            cx1_reg <= trig.cx;
            sy1_reg <= trig.sy;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= P3'(czsy_reg * sx1_reg);
            t2_reg <= P3'(czsy_reg * cx1_reg);
            t3_reg <= P3'(szsy_reg * sx1_reg);
            t4_reg <= P3'(szsy_reg * cx1_reg);
            u1_reg <= P3'(szcx_reg) <<< 16;
            u2_reg <= P3'(szsx_reg) <<< 16;
            u3_reg <= P3'(czcx_reg) <<< 16;
            u4_reg <= P3'(czsx_reg) <<< 16;
            czcy2_reg <= czcy_reg;
            szcy2_reg <= szcy_reg;
            cysx2_reg <= cysx_reg;
            cycx2_reg <= cycx_reg;
            sy2_reg <= sy1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg[0] <= (P3+1)'(t1_reg) + (P3+1)'(u1_reg);
            s_reg[1] <= (P3+1)'(u2_reg) - (P3+1)'(t2_reg);
            s_reg[2] <= (P3+1)'(u3_reg) - (P3+1)'(t3_reg);
            s_reg[3] <= (P3+1)'(u4_reg) + (P3+1)'(t4_reg);
            s_reg[4] <= (P3+1)'(czcy2_reg) <<< 16;
            s_reg[5] <= -((P3+1)'(cysx2_reg) <<< 16);
            sy3_reg <= sy2_reg;
        end
    end

    logic signed [P3:0] szcy3_reg, cycx3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            szcy3_reg <= -((P3+1)'(szcy2_reg) <<< 16);
            cycx3_reg <= (P3+1)'(cycx2_reg) <<< 16;
        end
    end

    function automatic q16_t rnd(input logic signed [P3:0] v);
        logic signed [P3:0] r;
        r = (v + ((P3+1)'(1) <<< 31)) >>> 32;
        if (r > (P3+1)'(ONE_Q16)) return ONE_Q16;
        if (r < -(P3+1)'(ONE_Q16)) return -ONE_Q16;
        return r[Q16_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            ent[0] <= rnd(s_reg[4]);
            ent[1] <= rnd(s_reg[0]);
            ent[2] <= rnd(s_reg[1]);
            ent[3] <= rnd(szcy3_reg);
            ent[4] <= rnd(s_reg[2]);
            ent[5] <= rnd(s_reg[3]);
            ent[6] <= (sy3_reg > ONE_Q16) ? ONE_Q16 :
                      (sy3_reg < -ONE_Q16) ? -ONE_Q16 : sy3_reg;
            ent[7] <= rnd(s_reg[5]);
            ent[8] <= rnd(cycx3_reg);
        end
    end

endmodule

// File: tb/tb.sv
// testbench for the euler xyz angle to rotation matrix block
`timescale 1ns / 1ps
module tb;
    import exm_pkg::*;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 6;
    localparam int N_RANDOM = 1450;
    localparam longint CYCLE_LIMIT = 400000;

    // fixed-point constants of the angle fold and the cordic
    localparam longint PI_Q29 = 64'sd1686629713;
    localparam longint HALF_PI_Q29 = 64'sd843314857;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint ONE = 64'sd65536;

    typedef struct packed {
        logic signed [17:0] a_z, a_y, a_x, o_z, o_y, o_x, n_z, n_y, n_x;
    } matrix_t;

    logic aclk;
    logic aresetn;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata;   // rot_x, rot_y, rot_z
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [167:0] m_axis_tdata;  // n_x n_y n_z o_x o_y o_z a_x a_y a_z

    int errors = 0;
    longint cycles = 0;
    bit long_hold = 0;
    bit hold_done = 0;

    euler_xyz_to_rotation_matrix #(.CORDIC_STAGES(STAGES)) dut (.*);

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint round_q16(input longint v, input int sh);
        longint r;
        r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (r > ONE) r = ONE;
        if (r < -ONE) r = -ONE;
        return r;
    endfunction

    function automatic longint angle_atan(input int i);
        longint tbl [10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                             16771758, 8387925, 4194219, 2097141, 1048575};
        if (i < 10) return tbl[i];
        return 64'sd1 <<< (29 - i);
    endfunction

    function automatic void sine_cosine(input logic signed [17:0] ang, output longint s,
                                        output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * 16384;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (z > HALF_PI_Q29) begin
            z -= PI_Q29;
            flip = 1;
        end else if (z < -HALF_PI_Q29) begin
            z += PI_Q29;
            flip = 1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= angle_atan(i);
            end else begin
                x += dx; y -= dy; z += angle_atan(i);
            end
        end
        c = round_q16(x, 14);
        s = round_q16(y, 14);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic matrix_t rotation_of(input logic [55:0] angles);
        longint sx, cx, sy, cy, sz, cz;
        matrix_t m;
        sine_cosine(angles[17:0], sx, cx);
        sine_cosine(angles[35:18], sy, cy);
        sine_cosine(angles[53:36], sz, cz);
        m.n_x = 18'(round_q16(cz * cy, 16));
        m.n_y = 18'(round_q16(cz * sy * sx + sz * cx * ONE, 32));
        m.n_z = 18'(round_q16(-cz * sy * cx + sz * sx * ONE, 32));
        m.o_x = 18'(round_q16(-sz * cy, 16));
        m.o_y = 18'(round_q16(cz * cx * ONE - sz * sy * sx, 32));
        m.o_z = 18'(round_q16(cz * sx * ONE + sz * sy * cx, 32));
        m.a_x = 18'(sy);
        m.a_y = 18'(round_q16(-cy * sx, 16));
        m.a_z = 18'(round_q16(cy * cx, 16));
        return m;
    endfunction

    class matrix_scoreboard;
        matrix_t pending[$];

        function void note_angles(input logic [55:0] angles);
            pending.insert(pending.size(), rotation_of(angles));
        endfunction

        task check_matrix(input logic [167:0] bus);
            matrix_t got, want;
            got = bus[161:0];
            if (pending.size() == 0) begin
                $display("unexpected matrix transaction %h", bus);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.n_x != want.n_x) report("n_x", got.n_x, want.n_x);
            if (got.n_y != want.n_y) report("n_y", got.n_y, want.n_y);
            if (got.n_z != want.n_z) report("n_z", got.n_z, want.n_z);
            if (got.o_x != want.o_x) report("o_x", got.o_x, want.o_x);
            if (got.o_y != want.o_y) report("o_y", got.o_y, want.o_y);
            if (got.o_z != want.o_z) report("o_z", got.o_z, want.o_z);
            if (got.a_x != want.a_x) report("a_x", got.a_x, want.a_x);
            if (got.a_y != want.a_y) report("a_y", got.a_y, want.a_y);
            if (got.a_z != want.a_z) report("a_z", got.a_z, want.a_z);
        endtask
    endclass

    matrix_scoreboard sb = new();

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) sb.note_angles(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_matrix(m_axis_tdata);
    end

    // receiver: own stall pattern, plus one long hold-off
    initial begin
        int mode;
        m_axis_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_axis_tready <= 0;
                repeat (200) @(negedge aclk);
                long_hold = 0;
            end
            mode = int'((cycles / 300) % 3);
            if (mode == 0) m_axis_tready <= 1;
            else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
            else m_axis_tready <= ($urandom_range(0, 2) == 0);
        end
    end

    task automatic send_angles(input logic signed [17:0] rx, input logic signed [17:0] ry,
                               input logic signed [17:0] rz);
        s_axis_tdata <= {2'b00, rz, ry, rx};
        s_axis_tvalid <= 1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    function automatic logic signed [17:0] some_angle();
        case ($urandom_range(0, 5))
            0: return 18'sh1ffff;
            1: return 18'sh20000;
            2: return 18'(51471 + $urandom_range(0, 8) - 4);   // near +-pi/2 fold edge
            3: return 18'(-51471 + $urandom_range(0, 8) - 4);
            4: return 18'(($urandom_range(0, 1) ? 102943 : -102943) + $urandom_range(0, 8) - 4);
            default: return 18'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [17:0] edges [] = '{18'sh1ffff, 18'sh20000, 0, 1, -1, 51471, 51472,
                                         -51471, -51472, 102943, -102944, 25736};
        int burst;
        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        foreach (edges[i]) send_angles(edges[i], edges[(i + 4) % 12], edges[(i + 7) % 12]);
        send_angles(18'sh15555, 18'sh2aaaa, 18'sh15555);
        send_angles(18'sh2aaaa, 18'sh15555, 18'sh2aaaa);
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            if (n >= 300 && !hold_done) begin
                long_hold = 1;
                hold_done = 1;
            end
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
                send_angles(some_angle(), some_angle(), some_angle());
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
